// ===== rtl/rvp_pkg.sv =====
`default_nettype none

package rvp_pkg;

   localparam int ANGLE_BITS     = 12;
   localparam int COORD_BITS     = 32;
   localparam int TRIG_FRAC_BITS = 16;

   // sine and cosine in [-1, 1] with sign
   localparam int TRIG_BITS = TRIG_FRAC_BITS + 2;
   // offset from pivot, grows by at most sqrt(3) through the rotations
   localparam int OFF_BITS  = COORD_BITS + 2;
   localparam int PROD_BITS = OFF_BITS + TRIG_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = COORD_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [OFF_BITS-1:0]   off_type;
   typedef logic signed [TRIG_BITS-1:0]  trig_val_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ANGLE_X = 3'd0,
      REG_ANGLE_Y = 3'd1,
      REG_ANGLE_Z = 3'd2,
      REG_PIVOT_X = 3'd3,
      REG_PIVOT_Y = 3'd4,
      REG_PIVOT_Z = 3'd5
   } reg_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      trig_val_type c;
      trig_val_type s;
   } cs_type;

   typedef cs_type [2:0] trig_type;

   typedef struct packed {
      logic                  load;
      axis_type              axis;
      logic [ANGLE_BITS-1:0] angle;
   } angle_wr_type;

endpackage

`default_nettype wire

// ===== rtl/rvp_rotate.sv =====
`default_nettype none

module rvp_rotate
   import rvp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire off_type      in_u,
   input  wire off_type      in_v,
   input  wire off_type      in_w,
   input  wire trig_val_type cos_val,
   input  wire trig_val_type sin_val,
   output logic              out_valid,
   output off_type           out_u,
   output off_type           out_v,
   output off_type           out_w
);

   localparam int SUM_BITS = PROD_BITS + 1;

   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [SUM_BITS-1:0]  sum_type;

   localparam sum_type HALF = sum_type'(1) << (TRIG_FRAC_BITS - 1);

   logic     m_valid_ff, m_valid_in;
   prod_type uc_ff, uc_in;
   prod_type vs_ff, vs_in;
   prod_type us_ff, us_in;
   prod_type vc_ff, vc_in;
   off_type  m_w_ff;

   logic     s_valid_ff, s_valid_in;
   off_type  u_ff, u_in;
   off_type  v_ff, v_in;
   off_type  w_ff;

   sum_type  sum_u, sum_v;
   sum_type  sh_u, sh_v;

   // products
   always_comb begin
      m_valid_in = in_valid;
      uc_in      = prod_type'(in_u) * prod_type'(cos_val);
      vs_in      = prod_type'(in_v) * prod_type'(sin_val);
      us_in      = prod_type'(in_u) * prod_type'(sin_val);
      vc_in      = prod_type'(in_v) * prod_type'(cos_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
      end
      uc_ff  <= uc_in;
      vs_ff  <= vs_in;
      us_ff  <= us_in;
      vc_ff  <= vc_in;
      m_w_ff <= in_w;
   end

   // sums, round half up, scale back
   always_comb begin
      s_valid_in = m_valid_ff;
      sum_u      = sum_type'(uc_ff) - sum_type'(vs_ff) + HALF;
      sum_v      = sum_type'(us_ff) + sum_type'(vc_ff) + HALF;
      sh_u       = sum_u >>> TRIG_FRAC_BITS;
      sh_v       = sum_v >>> TRIG_FRAC_BITS;
      u_in       = sh_u[OFF_BITS-1:0];
      v_in       = sh_v[OFF_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      w_ff <= m_w_ff;
   end

   assign out_valid = s_valid_ff;
   assign out_u     = u_ff;
   assign out_v     = v_ff;
   assign out_w     = w_ff;

endmodule

`default_nettype wire

// ===== rtl/rvp_trig.sv =====
`default_nettype none

module rvp_trig
   import rvp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire angle_wr_type wr,
   output logic              busy,
   output trig_type          trig
);

   localparam int QUARTER       = 2 ** (ANGLE_BITS - 2);
   localparam int TAB_DEPTH     = QUARTER + 1;
   localparam int TAB_ADDR_BITS = ANGLE_BITS - 1;
   localparam int TAB_BITS      = TRIG_FRAC_BITS + 1;

   localparam real HALF_PI      = 1.5707963267948966;
   localparam real QUARTER_REAL = real'(QUARTER);
   localparam real ONE_REAL     = 2.0 ** TRIG_FRAC_BITS;

   localparam trig_val_type ONE = trig_val_type'(1) << TRIG_FRAC_BITS;

   typedef logic [TAB_BITS-1:0] tab_type [TAB_DEPTH];

   typedef struct packed {
      logic                     neg;
      logic [TAB_ADDR_BITS-1:0] idx;
   } fold_type;

   function automatic tab_type build_sin_table();
      tab_type t;
      real     ang;
      for (int k = 0; k < TAB_DEPTH; k++) begin
         ang  = HALF_PI * real'(k) / QUARTER_REAL;
         t[k] = TAB_BITS'($rtoi($sin(ang) * ONE_REAL + 0.5));
      end
      return t;
   endfunction

   // quarter-wave fold of a binary angle
   function automatic fold_type fold(input logic [ANGLE_BITS-1:0] a);
      fold_type                 f;
      logic [1:0]               quad;
      logic [TAB_ADDR_BITS-1:0] r;
      quad  = a[ANGLE_BITS-1 -: 2];
      r     = TAB_ADDR_BITS'(a[ANGLE_BITS-3:0]);
      f.neg = quad[1];
      f.idx = quad[0] ? TAB_ADDR_BITS'(QUARTER) - r : r;
      return f;
   endfunction

   localparam tab_type SIN_TABLE = build_sin_table();

   logic [ANGLE_BITS-1:0] cos_angle;
   fold_type              sin_f, cos_f;

   logic                  pend_ff, pend_in;
   axis_type              axis_ff;
   logic                  sin_neg_ff, cos_neg_ff;
   logic [TAB_BITS-1:0]   sin_rom_ff, cos_rom_ff;

   trig_val_type          sin_mag, cos_mag;
   trig_type              trig_ff, trig_in;

   always_comb begin
      cos_angle = wr.angle + ANGLE_BITS'(QUARTER);
      sin_f     = fold(wr.angle);
      cos_f     = fold(cos_angle);
      pend_in   = wr.load;
   end

   // registered table read
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      if (wr.load) begin
         axis_ff    <= wr.axis;
         sin_neg_ff <= sin_f.neg;
         cos_neg_ff <= cos_f.neg;
         sin_rom_ff <= SIN_TABLE[sin_f.idx];
         cos_rom_ff <= SIN_TABLE[cos_f.idx];
      end
   end

   always_comb begin
      sin_mag = trig_val_type'(sin_rom_ff);
      cos_mag = trig_val_type'(cos_rom_ff);
      trig_in = trig_ff;
      if (pend_ff) begin
         trig_in[axis_ff].s = sin_neg_ff ? -sin_mag : sin_mag;
         trig_in[axis_ff].c = cos_neg_ff ? -cos_mag : cos_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            trig_ff[i].c <= ONE;
            trig_ff[i].s <= '0;
         end
      end else begin
         trig_ff <= trig_in;
      end
   end

   assign busy = pend_ff;
   assign trig = trig_ff;

   a_load_sets_busy: assert property (@(posedge clock) disable iff (reset)
      wr.load |=> pend_ff)
      else $error("angle write did not start a table load");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> !pend_ff)
      else $error("table load took more than one cycle");

   a_cos_x_range: assert property (@(posedge clock) disable iff (reset)
      (trig_ff[AXIS_X].c <= ONE) && (trig_ff[AXIS_X].c >= -ONE))
      else $error("cosine outside unit range");

endmodule

`default_nettype wire

// ===== rtl/vertex_rotate_about_pivot.sv =====
`default_nettype none

// vertex rotation about a pivot, x then y then z, signed q16.16 coordinates
//
// input: a vertex word on req_pos_x/y/z is taken at a rising edge with start
//    high and busy low; a new word can be taken every cycle while busy is low
// output: rsp_valid is high for exactly one cycle with rsp_rot_x/y/z; the
//    receiver cannot stall, so results stream out in input order
// config: csr_valid/csr_ready with csr_index and csr_data; index 0..2 are the
//    angles (full turn 4096), 3..5 the pivot; other indexes are dropped
// pipeline: 8 stages, i.e. the offset register, the product and sum registers
//    of each rotation and the output register; one vertex per cycle unless busy
// an angle write reads the quarter-wave sine rom twice, for sine and for cosine;
//    busy and !csr_ready hold for the one cycle of that read
// write config only with no vertex in flight
// reset (synchronous, active high): all angles and pivots zero, i.e. the
//    identity, and the pipeline empty

module vertex_rotate_about_pivot
   import rvp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      start,
   output logic                           busy,
   input  wire coord_type                 req_pos_x,
   input  wire coord_type                 req_pos_y,
   input  wire coord_type                 req_pos_z,

   output logic                           rsp_valid,
   output coord_type                      rsp_rot_x,
   output coord_type                      rsp_rot_y,
   output coord_type                      rsp_rot_z,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int LATENCY  = 8;
   localparam int SUM_BITS = OFF_BITS + 1;

   typedef logic signed [SUM_BITS-1:0] sum_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   function automatic coord_type sat(input sum_type v);
      logic [SUM_BITS-COORD_BITS:0] top;
      top = v[SUM_BITS-1:COORD_BITS-1];
      if ((top == '0) || (top == '1)) begin
         return v[COORD_BITS-1:0];
      end
      return v[SUM_BITS-1] ? COORD_MIN : COORD_MAX;
   endfunction

   logic         load_busy;
   logic         csr_fire;
   logic         accept;
   angle_wr_type angle_wr;
   trig_type     trig;

   logic [2:0]   pivot_we;
   coord_type    pivot_x_ff, pivot_x_in;
   coord_type    pivot_y_ff, pivot_y_in;
   coord_type    pivot_z_ff, pivot_z_in;

   logic         s0_valid_ff, s0_valid_in;
   off_type      dx_ff, dx_in;
   off_type      dy_ff, dy_in;
   off_type      dz_ff, dz_in;

   logic         rx_valid, ry_valid, rz_valid;
   off_type      rx_y, rx_z, rx_x;
   off_type      ry_z, ry_x, ry_y;
   off_type      rz_x, rz_y, rz_z;

   logic         out_valid_ff, out_valid_in;
   coord_type    out_x_ff, out_x_in;
   coord_type    out_y_ff, out_y_in;
   coord_type    out_z_ff, out_z_in;

   assign csr_ready = !load_busy;
   assign busy      = load_busy;
   assign csr_fire  = csr_valid && csr_ready;
   assign accept    = start && !load_busy;

   // register decode
   always_comb begin
      angle_wr.load  = 1'b0;
      angle_wr.axis  = AXIS_X;
      angle_wr.angle = csr_data[ANGLE_BITS-1:0];
      pivot_we       = '0;
      unique case (csr_index)
         REG_ANGLE_X: begin
            angle_wr.load = csr_fire;
            angle_wr.axis = AXIS_X;
         end
         REG_ANGLE_Y: begin
            angle_wr.load = csr_fire;
            angle_wr.axis = AXIS_Y;
         end
         REG_ANGLE_Z: begin
            angle_wr.load = csr_fire;
            angle_wr.axis = AXIS_Z;
         end
         REG_PIVOT_X: pivot_we[AXIS_X] = csr_fire;
         REG_PIVOT_Y: pivot_we[AXIS_Y] = csr_fire;
         REG_PIVOT_Z: pivot_we[AXIS_Z] = csr_fire;
         default: ;
      endcase
   end

   always_comb begin
      pivot_x_in = pivot_we[AXIS_X] ? coord_type'(csr_data) : pivot_x_ff;
      pivot_y_in = pivot_we[AXIS_Y] ? coord_type'(csr_data) : pivot_y_ff;
      pivot_z_in = pivot_we[AXIS_Z] ? coord_type'(csr_data) : pivot_z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_x_ff <= '0;
         pivot_y_ff <= '0;
         pivot_z_ff <= '0;
      end else begin
         pivot_x_ff <= pivot_x_in;
         pivot_y_ff <= pivot_y_in;
         pivot_z_ff <= pivot_z_in;
      end
   end

   rvp_trig u_trig (
      .clock (clock),
      .reset (reset),
      .wr    (angle_wr),
      .busy  (load_busy),
      .trig  (trig)
   );

   // offset from pivot
   always_comb begin
      s0_valid_in = accept;
      dx_in       = off_type'(req_pos_x) - off_type'(pivot_x_ff);
      dy_in       = off_type'(req_pos_y) - off_type'(pivot_y_ff);
      dz_in       = off_type'(req_pos_z) - off_type'(pivot_z_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      dz_ff <= dz_in;
   end

   // about x: (y, z)
   rvp_rotate u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_u      (dy_ff),
      .in_v      (dz_ff),
      .in_w      (dx_ff),
      .cos_val   (trig[AXIS_X].c),
      .sin_val   (trig[AXIS_X].s),
      .out_valid (rx_valid),
      .out_u     (rx_y),
      .out_v     (rx_z),
      .out_w     (rx_x)
   );

   // about y: (z, x)
   rvp_rotate u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rx_valid),
      .in_u      (rx_z),
      .in_v      (rx_x),
      .in_w      (rx_y),
      .cos_val   (trig[AXIS_Y].c),
      .sin_val   (trig[AXIS_Y].s),
      .out_valid (ry_valid),
      .out_u     (ry_z),
      .out_v     (ry_x),
      .out_w     (ry_y)
   );

   // about z: (x, y)
   rvp_rotate u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ry_valid),
      .in_u      (ry_x),
      .in_v      (ry_y),
      .in_w      (ry_z),
      .cos_val   (trig[AXIS_Z].c),
      .sin_val   (trig[AXIS_Z].s),
      .out_valid (rz_valid),
      .out_u     (rz_x),
      .out_v     (rz_y),
      .out_w     (rz_z)
   );

   // pivot back, saturate
   always_comb begin
      out_valid_in = rz_valid;
      out_x_in     = sat(sum_type'(rz_x) + sum_type'(pivot_x_ff));
      out_y_in     = sat(sum_type'(rz_y) + sum_type'(pivot_y_ff));
      out_z_in     = sat(sum_type'(rz_z) + sum_type'(pivot_z_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_z_ff <= out_z_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_rot_x = out_x_ff;
   assign rsp_rot_y = out_y_ff;
   assign rsp_rot_z = out_z_ff;

   a_word_comes_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted word did not reach the output");

   a_no_spurious_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result word without a matching input word");

endmodule

`default_nettype wire
